/* design/command_frame_receiver_defines.svh */
// Assertion macros for the command frame receiver.
// Used by the top level; each macro expects signals named clk and rst in scope.
`ifndef COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define CFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle where an antecedent holds.
`define CFR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cfr_pkg.sv */
// Shared types and constants for the command frame receiver.
// No dependencies; used by every module of the block.
package cfr_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic [7:0] MAX_LEN_RESET = 8'd200;

  localparam logic [7:0] CMD_FULL_DATA = 8'd0;
  localparam logic [7:0] CMD_ON_TIME = 8'd1;
  localparam logic [7:0] CMD_GAMMA = 8'd2;
  localparam logic [7:0] CMD_SENSORS = 8'd3;

  localparam logic [7:0] POS_LENGTH = 8'd1;
  localparam logic [7:0] POS_DATA0 = 8'd2;
  localparam logic [7:0] POS_DATA1 = 8'd3;
  localparam logic [7:0] POS_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BAD_CHECKSUM = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_FULL_DATA = 3'd1,
    ACT_ON_TIME = 3'd2,
    ACT_GAMMA = 3'd3,
    ACT_SENSOR_POWER = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_MATCH = 2'd1,
    CK_MISMATCH = 2'd2
  } ck_code_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         command_id;
    logic [2:0]         action;
    logic signed [15:0] on_time_value;
    logic [7:0]         gamma_setting;
    logic               sensors_on;
    logic               send_ack;
  } out_item_t;

endpackage

/* design/cfr_cfg_regs.sv */
// Configuration register file of the command frame receiver (APB-style port).
// Depends on cfr_pkg.
module cfr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfr_pkg::ADDR_W-1:0] paddr,
  input  logic [cfr_pkg::DATA_W-1:0] pwdata,
  output logic [cfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [7:0]                 max_len
);

  logic reg_sel;

  assign pready = 1'b1;
  assign reg_sel = (paddr[cfr_pkg::ADDR_W-1] == cfr_pkg::REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= cfr_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_len <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(cfr_pkg::DATA_W - 8){1'b0}}, max_len};
    end
  end

endmodule

/* design/cfr_frame_parser.sv */
// Input register and per-byte message state of the command frame receiver.
// Produces one decoded result on the last byte of a message. Depends on cfr_pkg.
module cfr_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfr_pkg::in_item_t  in_item,
  input  logic [7:0]         max_len,
  input  logic               res_free,
  output logic               res_fire,
  output cfr_pkg::out_item_t res_item
);

  logic              in_q_valid;
  cfr_pkg::in_item_t in_q;
  logic              step;

  logic [7:0]        byte_position;
  logic [7:0]        held_command;
  logic [7:0]        held_length;
  logic [7:0]        running_sum;
  logic [15:0]       first_data_pair;
  cfr_pkg::ck_code_t checksum_result;
  logic              overlong_flag;

  logic [7:0]        byte_position_next;
  logic [7:0]        held_command_next;
  logic [7:0]        held_length_next;
  logic [7:0]        running_sum_next;
  logic [15:0]       first_data_pair_next;
  cfr_pkg::ck_code_t checksum_result_next;
  logic              overlong_flag_next;

  logic [8:0]        ck_pos;
  logic [7:0]        b;
  cfr_pkg::status_t  status;

  assign step = in_q_valid && (!in_q.last_byte || res_free);
  assign in_ready = !in_q_valid || step;
  assign res_fire = step && in_q.last_byte;
  assign b = in_q.rx_byte;
  assign ck_pos = {1'b0, held_length} + 9'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  always_comb begin
    overlong_flag_next = overlong_flag || (byte_position == cfr_pkg::POS_MAX) ||
                         (byte_position >= max_len);
    held_command_next = (byte_position == 8'd0) ? b : held_command;
    held_length_next = (byte_position == cfr_pkg::POS_LENGTH) ? b : held_length;
    running_sum_next = running_sum;
    checksum_result_next = checksum_result;
    if ((byte_position >= cfr_pkg::POS_DATA0) && (checksum_result == cfr_pkg::CK_NONE)) begin
      if ({1'b0, byte_position} < ck_pos) begin
        running_sum_next = running_sum + b;
      end else if ({1'b0, byte_position} == ck_pos) begin
        checksum_result_next = (~running_sum == b) ? cfr_pkg::CK_MATCH : cfr_pkg::CK_MISMATCH;
      end
    end
    first_data_pair_next = first_data_pair;
    if (byte_position == cfr_pkg::POS_DATA0) begin
      first_data_pair_next[7:0] = b;
    end else if (byte_position == cfr_pkg::POS_DATA1) begin
      first_data_pair_next[15:8] = b;
    end
    byte_position_next = (byte_position == cfr_pkg::POS_MAX) ? byte_position
                                                              : byte_position + 8'd1;
  end

  always_comb begin
    if (overlong_flag_next) begin
      status = cfr_pkg::ST_TOO_LONG;
    end else if (checksum_result_next == cfr_pkg::CK_NONE) begin
      status = cfr_pkg::ST_TRUNCATED;
    end else if (checksum_result_next == cfr_pkg::CK_MISMATCH) begin
      status = cfr_pkg::ST_BAD_CHECKSUM;
    end else begin
      status = cfr_pkg::ST_ACCEPTED;
    end
  end

  always_comb begin
    res_item = '0;
    res_item.status = status;
    res_item.command_id = held_command_next;
    if (status == cfr_pkg::ST_ACCEPTED) begin
      unique case (held_command_next)
        cfr_pkg::CMD_FULL_DATA: begin
          res_item.action = cfr_pkg::ACT_FULL_DATA;
        end
        cfr_pkg::CMD_ON_TIME: begin
          res_item.action = cfr_pkg::ACT_ON_TIME;
          res_item.on_time_value = $signed(first_data_pair_next);
          res_item.send_ack = 1'b1;
        end
        cfr_pkg::CMD_GAMMA: begin
          res_item.action = cfr_pkg::ACT_GAMMA;
          res_item.gamma_setting = first_data_pair_next[7:0];
          res_item.send_ack = 1'b1;
        end
        cfr_pkg::CMD_SENSORS: begin
          res_item.action = cfr_pkg::ACT_SENSOR_POWER;
          res_item.sensors_on = (first_data_pair_next[7:0] == 8'd1);
        end
        default: begin
          res_item.action = cfr_pkg::ACT_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_fire) begin
      byte_position <= '0;
      held_command <= '0;
      held_length <= '0;
      running_sum <= '0;
      first_data_pair <= '0;
      checksum_result <= cfr_pkg::CK_NONE;
      overlong_flag <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      held_command <= held_command_next;
      held_length <= held_length_next;
      running_sum <= running_sum_next;
      first_data_pair <= first_data_pair_next;
      checksum_result <= checksum_result_next;
      overlong_flag <= overlong_flag_next;
    end
  end

endmodule

/* design/command_frame_receiver.sv */
// Top level of the command frame receiver: configuration, parser and result register.
// Depends on cfr_pkg, cfr_cfg_regs, cfr_frame_parser and the assertion macro header.
//
// Channel   Direction  Handshake                      Payload
// input     in         in_valid / in_ready            in_item (cfr_pkg::in_item_t)
// output    out        out_valid / out_ready          out_item (cfr_pkg::out_item_t)
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One byte is taken every cycle unless a last byte waits in the input register for the result register.
// The rate is set by the single parser stage between the input and result registers.
// Reset clears the message state and sets max_message_length to 200.
// While a result waits, bytes keep flowing until the next last byte needs the register.
`include "command_frame_receiver_defines.svh"

module command_frame_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cfr_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cfr_pkg::out_item_t         out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfr_pkg::ADDR_W-1:0] paddr,
  input  logic [cfr_pkg::DATA_W-1:0] pwdata,
  output logic [cfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  logic               res_free;
  logic               res_fire;
  cfr_pkg::out_item_t res_item;
  logic [7:0]         max_len;

  cfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  cfr_frame_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .max_len  (max_len),
    .res_free (res_free),
    .res_fire (res_fire),
    .res_item (res_item)
  );

  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_item <= res_item;
    end
  end

  `CFR_ASSERT_IMPLY(a_reject_no_action, out_valid && (out_item.status != cfr_pkg::ST_ACCEPTED), (out_item.action == cfr_pkg::ACT_NONE) && !out_item.send_ack, "Rejected message carries an action.")
  `CFR_ASSERT_IMPLY(a_ack_actions, out_valid && out_item.send_ack, (out_item.action == cfr_pkg::ACT_ON_TIME) || (out_item.action == cfr_pkg::ACT_GAMMA), "Acknowledge flagged for a command that takes none.")
  `CFR_ASSERT_IMPLY(a_sensors_action, out_valid && out_item.sensors_on, out_item.action == cfr_pkg::ACT_SENSOR_POWER, "Sensor power flag without sensor power action.")
  `CFR_ASSERT_NEXT(a_result_loaded, res_fire, out_valid, "Result lost on its way to the output register.")

endmodule

/* verif/command_frame_receiver_tb.sv */
// Self-checking testbench for command_frame_receiver: drives framed bytes and
// configuration writes, and checks every result against a built-in predictor.
// Depends on cfr_pkg and the command_frame_receiver RTL.
module command_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BYTES = 150;
  localparam logic [ADDR_W-1:0] MAX_LEN_ADDR = ADDR_W'(4 * REG_MAX_LEN);

  typedef logic [7:0] frame_t[$];

  class frame_scoreboard;
    logic [7:0]  max_len;
    logic [7:0]  pos;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [15:0] pair;
    ck_code_t    ck;
    logic        overlong;
    out_item_t   expected_q[$];
    int          mismatches;

    function new();
      max_len = MAX_LEN_RESET;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      pos = '0;
      cmd = '0;
      len = '0;
      sum = '0;
      pair = '0;
      ck = CK_NONE;
      overlong = 1'b0;
    endfunction

    function void set_max_len(logic [7:0] v);
      max_len = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
    endfunction

    function string show(out_item_t r);
      return $sformatf("status=%0d cmd=%02h action=%0d on_time=%0d gamma=%02h sensors=%0b ack=%0b",
                       r.status, r.command_id, r.action, r.on_time_value, r.gamma_setting,
                       r.sensors_on, r.send_ack);
    endfunction

    function void note_byte(in_item_t it);
      logic [8:0] ck_at;
      logic [7:0] b;
      logic [7:0] inv;
      out_item_t  r;
      b = it.rx_byte;
      ck_at = {1'b0, len} + 9'd2;
      inv = ~sum;
      if (pos == POS_MAX || ({1'b0, pos} + 9'd1) > {1'b0, max_len}) overlong = 1'b1;
      if (pos == 8'd0) begin
        cmd = b;
      end else if (pos == POS_LENGTH) begin
        len = b;
      end else if (ck == CK_NONE) begin
        if ({1'b0, pos} < ck_at) sum = sum + b;
        else if ({1'b0, pos} == ck_at) ck = (inv == b) ? CK_MATCH : CK_MISMATCH;
      end
      if (pos == POS_DATA0) pair[7:0] = b;
      else if (pos == POS_DATA1) pair[15:8] = b;
      if (pos != POS_MAX) pos = pos + 8'd1;
      if (!it.last_byte) return;

      r = '0;
      r.command_id = cmd;
      if (overlong) begin
        r.status = ST_TOO_LONG;
      end else if (ck == CK_NONE) begin
        r.status = ST_TRUNCATED;
      end else if (ck == CK_MISMATCH) begin
        r.status = ST_BAD_CHECKSUM;
      end else begin
        r.status = ST_ACCEPTED;
        case (cmd)
          CMD_FULL_DATA: begin
            r.action = ACT_FULL_DATA;
          end
          CMD_ON_TIME: begin
            r.action = ACT_ON_TIME;
            r.on_time_value = pair;
            r.send_ack = 1'b1;
          end
          CMD_GAMMA: begin
            r.action = ACT_GAMMA;
            r.gamma_setting = pair[7:0];
            r.send_ack = 1'b1;
          end
          CMD_SENSORS: begin
            r.action = ACT_SENSOR_POWER;
            r.sensors_on = (pair[7:0] == 8'd1);
          end
          default: begin
            r.action = ACT_NONE;
          end
        endcase
      end
      expected_q.push_back(r);
      clear();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      logic      bad;
      if (expected_q.size() == 0) begin
        report_mismatch({"result with none pending: ", show(got)});
        return;
      end
      exp_r = expected_q.pop_front();
      bad = (got.status !== exp_r.status) || (got.command_id !== exp_r.command_id) ||
            (got.action !== exp_r.action) || (got.on_time_value !== exp_r.on_time_value) ||
            (got.gamma_setting !== exp_r.gamma_setting) ||
            (got.sensors_on !== exp_r.sensors_on) || (got.send_ack !== exp_r.send_ack);
      if (bad) report_mismatch({"expected ", show(exp_r), " got ", show(got)});
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  frame_scoreboard sb = new();
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  sent_bytes = 0;
  bit  steady_in = 1'b0;
  bit  steady_out = 1'b0;

  command_frame_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic frame_t sum_frame(logic [7:0] cmd, logic [7:0] len);
    frame_t     f;
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    f.push_back(cmd);
    f.push_back(len);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      if (i == 0 && cmd == CMD_SENSORS && $urandom_range(0, 1) == 1) b = 8'd1;
      sum = sum + b;
      f.push_back(b);
    end
    f.push_back(~sum);
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t     f;
    logic [7:0] cmd;
    logic [7:0] len;
    int         kind;
    int         r;
    int         n;
    int         cut;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      n = $urandom_range(1, 8);
      repeat (n) f.push_back(8'($urandom));
      return f;
    end
    cmd = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 85) len = 8'($urandom_range(0, 6));
    else if (r < 99) len = 8'($urandom_range(7, 40));
    else len = 8'($urandom_range(100, 255));
    f = sum_frame(cmd, len);
    if (kind >= 60 && kind < 70) begin
      f[f.size() - 1] = f[f.size() - 1] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 70 && kind < 80) begin
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end else if (kind >= 80) begin
      n = $urandom_range(1, 4);
      repeat (n) f.push_back(8'($urandom));
    end
    return f;
  endfunction

  task automatic send_byte(in_item_t it);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(frame_t f);
    in_item_t it;
    if ($urandom_range(0, 9) == 0) steady_in = !steady_in;
    foreach (f[i]) begin
      it.rx_byte = f[i];
      it.last_byte = (i == f.size() - 1);
      send_byte(it);
    end
    sent_bytes += f.size();
  endtask

  task automatic apb_access(bit wr, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] wd,
                            output logic [DATA_W-1:0] rd);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = a;
    pwdata = wd;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_max_len(logic [7:0] v);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, MAX_LEN_ADDR, '0, rd);
    if (rd !== DATA_W'(v))
      sb.report_mismatch($sformatf("max_message_length read %0d, expected %0d", rd, v));
  endtask

  task automatic write_max_len(logic [7:0] v);
    logic [DATA_W-1:0] rd;
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    apb_access(1'b1, MAX_LEN_ADDR, DATA_W'(v), rd);
    sb.set_max_len(v);
    check_max_len(v);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!steady_out) stall_left = pick_gap();
      if ($urandom_range(0, 199) == 0) steady_out = !steady_out;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] phase_max[6];
    frame_t     f;
    int         start;
    int         frames;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_max_len(MAX_LEN_RESET);

    // Every command, short data read raw, a lone byte, an unknown command and a bad sum.
    f = '{8'h01, 8'h02, 8'hFF, 8'h7F, 8'h81};
    send_frame(f);
    f = '{8'h02, 8'h01, 8'h80, 8'h7F};
    send_frame(f);
    f = '{8'h03, 8'h01, 8'h01, 8'hFE};
    send_frame(f);
    f = '{8'h00, 8'h00, 8'hFF};
    send_frame(f);
    f = '{8'hFF};
    send_frame(f);
    f = '{8'hFF, 8'h00, 8'hFF};
    send_frame(f);
    f = '{8'h01, 8'h00, 8'hFF, 8'h80};
    send_frame(f);
    f = '{8'h03, 8'h01, 8'h01, 8'h00};
    send_frame(f);

    phase_max = '{8'd255, 8'd0, 8'($urandom_range(1, 12)), 8'($urandom_range(3, 10)),
                  8'($urandom_range(13, 254)), 8'd200};
    foreach (phase_max[p]) begin
      write_max_len(phase_max[p]);
      if (phase_max[p] == 8'd255) begin
        send_frame(sum_frame(CMD_ON_TIME, 8'd255));
        send_frame(sum_frame(CMD_GAMMA, 8'd252));
      end
      start = sent_bytes;
      frames = 0;
      while (frames < 8 || sent_bytes - start < PHASE_BYTES) begin
        send_frame(random_frame());
        frames++;
      end
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
